FILE: src/bpq_pkg.sv
// Shared types, codes and defaults for the bitmap priority ready queue.
`timescale 1ns / 1ps
package bpq_pkg;

  localparam int PRIO_LEVELS_DEF = 64;
  localparam int WORD_BITS_DEF   = 32;
  localparam int MAX_ITEMS_DEF   = 64;

  localparam int FIELD_W = 6;

  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;

  localparam logic STATUS_DONE     = 1'b0;
  localparam logic STATUS_REJECTED = 1'b1;

  typedef enum logic [1:0] {
    CMD_ADD,
    CMD_REMOVE,
    CMD_QUERY,
    CMD_REJECT
  } cmd_t;

  typedef struct packed {
    cmd_t                 cmd;
    logic [FIELD_W-1:0]   id;
    logic [FIELD_W-1:0]   lv;
  } req_t;

  typedef struct packed {
    logic valid;
    req_t req;
  } qhead_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_RM_LVL,
    ST_RM,
    ST_FIND,
    ST_WORD,
    ST_OUT
  } st_t;

endpackage

FILE: src/bpq_if.sv
// Request and result channel interfaces.
`timescale 1ns / 1ps
interface bpq_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [5:0] item_id;
  logic [5:0] priority_req;
  modport source (output valid, action, item_id, priority_req, input ready);
  modport sink (input valid, action, item_id, priority_req, output ready);
endinterface

interface bpq_out_if;
  logic       valid;
  logic       ready;
  logic       status;
  logic       is_empty;
  logic [5:0] head_item;
  logic [5:0] head_priority;
  modport source (output valid, status, is_empty, head_item, head_priority, input ready);
  modport sink (input valid, status, is_empty, head_item, head_priority, output ready);
endinterface

FILE: src/bpq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: src/bpq_front.sv
// Front end: accepts requests, range-checks them and queues them for the back end.
`timescale 1ns / 1ps
module bpq_front #(
  parameter int PRIO_LEVELS = bpq_pkg::PRIO_LEVELS_DEF,
  parameter int MAX_ITEMS   = bpq_pkg::MAX_ITEMS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  bpq_in_if.sink         in_ch,
  output bpq_pkg::qhead_t q_head,
  input  logic           q_pop
);
  bpq_pkg::req_t slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  bpq_pkg::req_t cls;
  logic push, pop;

  always_comb begin
    cls.id  = in_ch.item_id;
    cls.lv  = in_ch.priority_req;
    case (in_ch.action)
      bpq_pkg::ACT_ADD: begin
        if (32'(in_ch.item_id) >= 32'(MAX_ITEMS) ||
            32'(in_ch.priority_req) >= 32'(PRIO_LEVELS)) begin
          cls.cmd = bpq_pkg::CMD_REJECT;
        end else begin
          cls.cmd = bpq_pkg::CMD_ADD;
        end
      end
      bpq_pkg::ACT_REMOVE: begin
        if (32'(in_ch.item_id) >= 32'(MAX_ITEMS)) begin
          cls.cmd = bpq_pkg::CMD_REJECT;
        end else begin
          cls.cmd = bpq_pkg::CMD_REMOVE;
        end
      end
      default: cls.cmd = bpq_pkg::CMD_QUERY;
    endcase
  end

  assign in_ch.ready  = (cnt_r != 2'd2);
  assign push         = in_ch.valid && in_ch.ready;
  assign pop          = q_pop && (cnt_r != 2'd0);
  assign q_head.valid = (cnt_r != 2'd0);
  assign q_head.req   = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end
endmodule

FILE: src/bpq_back.sv
// Back end: FIFO link updates, bitmap upkeep, head lookup and result register.
`timescale 1ns / 1ps
module bpq_back #(
  parameter int PRIO_LEVELS = bpq_pkg::PRIO_LEVELS_DEF,
  parameter int WORD_BITS   = bpq_pkg::WORD_BITS_DEF,
  parameter int MAX_ITEMS   = bpq_pkg::MAX_ITEMS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  bpq_pkg::qhead_t q_head,
  output logic            q_pop,
  bpq_out_if.source       out_ch
);
  localparam int IW = $clog2(MAX_ITEMS);
  localparam int LW = $clog2(PRIO_LEVELS);
  localparam int NG = (PRIO_LEVELS + WORD_BITS - 1) / WORD_BITS;
  localparam int GW = (NG > 1) ? $clog2(NG) : 1;
  localparam int BW = $clog2(WORD_BITS);
  localparam int MW = NG * WORD_BITS;

  bpq_pkg::st_t  state_r, state_nxt;
  bpq_pkg::cmd_t cmd_r, cmd_nxt;
  logic [IW-1:0] id_r, id_nxt;
  logic [LW-1:0] lv_r, lv_nxt;
  logic [LW-1:0] top_r, top_nxt;
  logic [GW-1:0] grp_r, grp_nxt;
  logic          rej_r, rej_nxt, any_r, any_nxt;
  logic [MAX_ITEMS-1:0] queued_r, queued_nxt;
  logic [MW-1:0]        lmap_r, lmap_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic                out_status_r, out_status_nxt, out_empty_r, out_empty_nxt;
  logic [5:0]          out_item_r, out_item_nxt, out_prio_r, out_prio_nxt;

  logic          head_we, tail_we, next_we, prev_we, lvl_we;
  logic [LW-1:0] head_waddr, tail_waddr, head_raddr, tail_raddr;
  logic [IW-1:0] head_wdata, tail_wdata, head_rdata, tail_rdata;
  logic [IW-1:0] next_waddr, prev_waddr, next_wdata, prev_wdata, next_rdata, prev_rdata;
  logic [IW-1:0] lvl_waddr, lvl_raddr;
  logic [LW-1:0] lvl_wdata, lvl_rdata;

  logic [WORD_BITS-1:0] word;
  logic [BW-1:0]        low_idx;
  logic [31:0]          top_full;
  logic                 first, last;

  bpq_ram #(.WIDTH(IW), .DEPTH(PRIO_LEVELS)) u_head (
    .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
    .raddr(head_raddr), .rdata(head_rdata));
  bpq_ram #(.WIDTH(IW), .DEPTH(PRIO_LEVELS)) u_tail (
    .clk(clk), .we(tail_we), .waddr(tail_waddr), .wdata(tail_wdata),
    .raddr(tail_raddr), .rdata(tail_rdata));
  bpq_ram #(.WIDTH(IW), .DEPTH(MAX_ITEMS)) u_next (
    .clk(clk), .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
    .raddr(id_r), .rdata(next_rdata));
  bpq_ram #(.WIDTH(IW), .DEPTH(MAX_ITEMS)) u_prev (
    .clk(clk), .we(prev_we), .waddr(prev_waddr), .wdata(prev_wdata),
    .raddr(id_r), .rdata(prev_rdata));
  bpq_ram #(.WIDTH(LW), .DEPTH(MAX_ITEMS)) u_lvl (
    .clk(clk), .we(lvl_we), .waddr(lvl_waddr), .wdata(lvl_wdata),
    .raddr(lvl_raddr), .rdata(lvl_rdata));

  // Lowest set bit of the selected word.
  always_comb begin
    word    = lmap_r[grp_r * WORD_BITS +: WORD_BITS];
    low_idx = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (word[b]) low_idx = BW'(b);
    end
    top_full = 32'(grp_r) * 32'(WORD_BITS) + 32'(low_idx);
  end

  assign first = (head_rdata == id_r);
  assign last  = (tail_rdata == id_r);

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    id_nxt         = id_r;
    lv_nxt         = lv_r;
    top_nxt        = top_r;
    grp_nxt        = grp_r;
    rej_nxt        = rej_r;
    any_nxt        = any_r;
    queued_nxt     = queued_r;
    lmap_nxt       = lmap_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_empty_nxt  = out_empty_r;
    out_item_nxt   = out_item_r;
    out_prio_nxt   = out_prio_r;
    q_pop          = 1'b0;
    head_we = 1'b0; tail_we = 1'b0; next_we = 1'b0; prev_we = 1'b0; lvl_we = 1'b0;
    head_waddr = lv_r; head_wdata = id_r;
    tail_waddr = lv_r; tail_wdata = id_r;
    next_waddr = id_r; next_wdata = id_r;
    prev_waddr = id_r; prev_wdata = id_r;
    lvl_waddr  = id_r; lvl_wdata  = lv_r;
    head_raddr = lv_r;
    tail_raddr = lv_r;
    lvl_raddr  = id_r;
    case (state_r)
      bpq_pkg::ST_IDLE: begin
        lvl_raddr  = IW'(q_head.req.id);
        tail_raddr = LW'(q_head.req.lv);
        if (q_head.valid) begin
          q_pop   = 1'b1;
          cmd_nxt = q_head.req.cmd;
          id_nxt  = IW'(q_head.req.id);
          lv_nxt  = LW'(q_head.req.lv);
          rej_nxt = 1'b0;
          case (q_head.req.cmd)
            bpq_pkg::CMD_ADD: begin
              if (queued_r[IW'(q_head.req.id)]) begin
                rej_nxt   = 1'b1;
                state_nxt = bpq_pkg::ST_FIND;
              end else begin
                state_nxt = bpq_pkg::ST_ADD;
              end
            end
            bpq_pkg::CMD_REMOVE: begin
              if (!queued_r[IW'(q_head.req.id)]) begin
                rej_nxt   = 1'b1;
                state_nxt = bpq_pkg::ST_FIND;
              end else begin
                state_nxt = bpq_pkg::ST_RM_LVL;
              end
            end
            bpq_pkg::CMD_REJECT: begin
              rej_nxt   = 1'b1;
              state_nxt = bpq_pkg::ST_FIND;
            end
            default: state_nxt = bpq_pkg::ST_FIND;
          endcase
        end
      end
      bpq_pkg::ST_ADD: begin
        // Append at the tail; link to the old tail when the level is busy.
        if (lmap_r[lv_r]) begin
          next_we    = 1'b1;
          next_waddr = tail_rdata;
          prev_we    = 1'b1;
          prev_wdata = tail_rdata;
        end else begin
          head_we = 1'b1;
        end
        tail_we            = 1'b1;
        lvl_we             = 1'b1;
        queued_nxt[id_r]   = 1'b1;
        lmap_nxt[lv_r]     = 1'b1;
        state_nxt          = bpq_pkg::ST_FIND;
      end
      bpq_pkg::ST_RM_LVL: begin
        lv_nxt     = lvl_rdata;
        head_raddr = lvl_rdata;
        tail_raddr = lvl_rdata;
        state_nxt  = bpq_pkg::ST_RM;
      end
      bpq_pkg::ST_RM: begin
        if (first && last) begin
          lmap_nxt[lv_r] = 1'b0;
        end else if (first) begin
          head_we    = 1'b1;
          head_wdata = next_rdata;
        end else if (last) begin
          tail_we    = 1'b1;
          tail_wdata = prev_rdata;
        end else begin
          next_we    = 1'b1;
          next_waddr = prev_rdata;
          next_wdata = next_rdata;
          prev_we    = 1'b1;
          prev_waddr = next_rdata;
          prev_wdata = prev_rdata;
        end
        queued_nxt[id_r] = 1'b0;
        state_nxt        = bpq_pkg::ST_FIND;
      end
      bpq_pkg::ST_FIND: begin
        // Group bit is the OR of its word; take the lowest busy group.
        any_nxt = 1'b0;
        grp_nxt = '0;
        for (int g = NG - 1; g >= 0; g--) begin
          if (|lmap_r[g * WORD_BITS +: WORD_BITS]) begin
            any_nxt = 1'b1;
            grp_nxt = GW'(g);
          end
        end
        state_nxt = bpq_pkg::ST_WORD;
      end
      bpq_pkg::ST_WORD: begin
        top_nxt    = LW'(top_full);
        head_raddr = LW'(top_full);
        state_nxt  = bpq_pkg::ST_OUT;
      end
      bpq_pkg::ST_OUT: begin
        head_raddr = top_r;
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = rej_r ? bpq_pkg::STATUS_REJECTED : bpq_pkg::STATUS_DONE;
          out_empty_nxt  = !any_r;
          out_item_nxt   = any_r ? 6'(head_rdata) : 6'd0;
          out_prio_nxt   = any_r ? 6'(top_r) : 6'd0;
          state_nxt      = bpq_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bpq_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bpq_pkg::ST_IDLE;
      queued_r    <= '0;
      lmap_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      queued_r    <= queued_nxt;
      lmap_r      <= lmap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    id_r         <= id_nxt;
    lv_r         <= lv_nxt;
    top_r        <= top_nxt;
    grp_r        <= grp_nxt;
    rej_r        <= rej_nxt;
    any_r        <= any_nxt;
    out_status_r <= out_status_nxt;
    out_empty_r  <= out_empty_nxt;
    out_item_r   <= out_item_nxt;
    out_prio_r   <= out_prio_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.is_empty      = out_empty_r;
  assign out_ch.head_item     = out_item_r;
  assign out_ch.head_priority = out_prio_r;
endmodule

FILE: src/bitmap_priority_ready_queue_top.sv
// Top level of the bitmap priority ready queue.
`timescale 1ns / 1ps
// Ready queue of item ids with one FIFO per priority level (0 highest) and a
// two-level bitmap over the levels. Each request (add, remove, query) yields
// one result: status, empty flag and the head of the highest busy level. The
// front end buffers up to two requests; the back end handles one at a time:
// add appends at the tail, remove reads the item's level then unlinks it, via
// registered reads of the head/tail/link RAMs; all end in the two-step group
// then word bitmap search. A result waits in an output register.
module bitmap_priority_ready_queue_top #(
  parameter int PRIO_LEVELS = bpq_pkg::PRIO_LEVELS_DEF,
  parameter int WORD_BITS   = bpq_pkg::WORD_BITS_DEF,
  parameter int MAX_ITEMS   = bpq_pkg::MAX_ITEMS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  bpq_in_if.sink    in_ch,
  bpq_out_if.source out_ch
);
  bpq_pkg::qhead_t q_head;
  logic            q_pop;

  bpq_front #(.PRIO_LEVELS(PRIO_LEVELS), .MAX_ITEMS(MAX_ITEMS)) u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .q_head(q_head), .q_pop(q_pop));

  bpq_back #(.PRIO_LEVELS(PRIO_LEVELS), .WORD_BITS(WORD_BITS),
             .MAX_ITEMS(MAX_ITEMS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_head(q_head), .q_pop(q_pop), .out_ch(out_ch));

`ifndef SYNTH
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.is_empty |-> out_ch.head_item == 6'd0 &&
      out_ch.head_priority == 6'd0)
    else $error("empty result carries a nonzero head");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid right after reset");

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_head.valid)
    else $error("back end popped an empty request queue");
`endif
endmodule
